@@ sv/vehicle_drive_mode_controller_core_assert.svh @@
// Assertion macros shared by the drive-mode controller RTL.
// Used inside modules that have clk and rst_n in scope.
`ifndef VEHICLE_DRIVE_MODE_CONTROLLER_CORE_ASSERT_SVH
`define VEHICLE_DRIVE_MODE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define VDMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define VDMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/vdmc_pkg.sv @@
// Shared constants, codes and types for the drive-mode controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vdmc_pkg;

  localparam int ADC_BITS           = 12;
  localparam int THROTTLE_FRAC_BITS = 15;
  localparam int CMD_W              = 16;
  localparam int CFG_W              = 16;
  localparam int CFG_IDX_W          = 3;
  localparam int CNT_W              = $clog2(THROTTLE_FRAC_BITS + 1);

  localparam logic [CMD_W-1:0] FULL_THROTTLE = CMD_W'(1) << THROTTLE_FRAC_BITS;
  localparam logic signed [CMD_W-1:0] VEL_FWD = 16'sd100;
  localparam logic signed [CMD_W-1:0] VEL_REV = -16'sd100;

  // Drive modes
  localparam logic [1:0] MODE_PARK    = 2'd0;
  localparam logic [1:0] MODE_DRIVE   = 2'd1;
  localparam logic [1:0] MODE_REVERSE = 2'd2;
  localparam logic [1:0] MODE_CRUISE  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_TYPE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_DEADZONE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_FULL_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_THROTTLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_THROTTLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_VELOCITY = 3'd5;

  // Divider request and response
  typedef struct packed {
    logic                start;
    logic [ADC_BITS-1:0] dividend;
    logic [ADC_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                          done;
    logic [THROTTLE_FRAC_BITS-1:0] quot;
  } div_rsp_t;

endpackage

@@ sv/vehicle_drive_mode_controller_core.sv @@
// Drive-mode controller top level: config registers, tick sequencer, mode logic.
// Depends on vdmc_pkg, vdmc_div and the assertion macro header.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid / in_stall): one control tick per transfer carrying
//   the raw throttle sample and the pin and flag levels.
//   Result channel (out_valid / out_stall): one command per tick with throttle,
//   velocity, the mode that produced it and the mode after the tick.
//   Config port: cfg_we with cfg_index and cfg_data writes one register per
//   cycle; write only while no tick is in flight.
//   Divider: the serial divider works out the 15 quotient bits of the throttle
//   map one at a time, then the command is loaded into the output register.
//   Flow control: in_stall stays high while a tick is being worked on, and
//   drops once its result sits in the output register.
//   A new tick is taken while the previous result still waits to be taken.
//   If out_stall holds the previous result, the finished tick waits in place.
//   Reset (rst_n low, synchronous): mode goes to park, config registers take
//   their defaults, no result is pending.
//
module vehicle_drive_mode_controller_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // Config port
  input  logic                               cfg_we,
  input  logic [vdmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vdmc_pkg::CFG_W-1:0]         cfg_data,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [vdmc_pkg::ADC_BITS-1:0]      in_throttle_raw,
  input  logic                               in_brake_pin,
  input  logic                               in_regen_pin,
  input  logic                               in_selector_pin_a,
  input  logic                               in_selector_pin_b,
  input  logic                               in_charge_below_limit,
  input  logic                               in_temperature_ok,
  input  logic                               in_speed_below_limit,
  input  logic                               in_cruise_request,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [vdmc_pkg::CMD_W-1:0]         out_throttle_cmd,
  output logic signed [vdmc_pkg::CMD_W-1:0]  out_velocity_cmd,
  output logic [1:0]                         out_mode_used,
  output logic [1:0]                         out_mode_next
);
  import vdmc_pkg::*;
  `include "vehicle_drive_mode_controller_core_assert.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Config registers
  logic                      motor_type_r;
  logic [ADC_BITS-1:0]       adc_deadzone_r;
  logic [ADC_BITS-1:0]       adc_full_scale_r;
  logic [CMD_W-1:0]          min_throttle_r;
  logic [CMD_W-1:0]          cruise_throttle_r;
  logic signed [CMD_W-1:0]   cruise_velocity_r;

  // Sequencer and tick state
  logic [1:0]                st_r, st_nxt;
  logic [1:0]                mode_r, mode_nxt;
  logic                      accept;
  logic                      load_out;
  logic                      zero_r, full_r;
  logic                      brake_r, regen_r, sel_a_r, sel_b_r;
  logic                      charge_r, temp_r, slow_r, cruise_r;
  logic [CMD_W-1:0]          pedal_r, pedal_nxt;

  // Command forming
  logic                      sel_drive, sel_rev, sel_park;
  logic [CMD_W-1:0]          mn_thr, cr_thr;
  logic [CMD_W-1:0]          thr;
  logic signed [CMD_W-1:0]   vel;
  logic                      regen_case;

  // Output register
  logic                      out_valid_r;
  logic [CMD_W-1:0]          out_thr_r;
  logic signed [CMD_W-1:0]   out_vel_r;
  logic [1:0]                out_used_r, out_next_r;

  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  assign in_stall = (st_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_out = (st_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_type_r      <= 1'b1;
      adc_deadzone_r    <= ADC_BITS'(100);
      adc_full_scale_r  <= {ADC_BITS{1'b1}};
      min_throttle_r    <= '0;
      cruise_throttle_r <= FULL_THROTTLE;
      cruise_velocity_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MOTOR_TYPE:      motor_type_r      <= cfg_data[0];
        CFG_ADC_DEADZONE:    adc_deadzone_r    <= cfg_data[ADC_BITS-1:0];
        CFG_ADC_FULL_SCALE:  adc_full_scale_r  <= cfg_data[ADC_BITS-1:0];
        CFG_MIN_THROTTLE:    min_throttle_r    <= cfg_data[CMD_W-1:0];
        CFG_CRUISE_THROTTLE: cruise_throttle_r <= cfg_data[CMD_W-1:0];
        CFG_CRUISE_VELOCITY: cruise_velocity_r <= signed'(cfg_data[CMD_W-1:0]);
        default: ;
      endcase
    end
  end

  // Launch the divider on the input transfer
  assign div_req.start    = accept;
  assign div_req.dividend = in_throttle_raw - adc_deadzone_r;
  assign div_req.divisor  = adc_full_scale_r - adc_deadzone_r;

  vdmc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Capture the tick and classify the sample
  always_ff @(posedge clk) begin
    if (accept) begin
      zero_r   <= (in_throttle_raw <= adc_deadzone_r);
      full_r   <= (adc_full_scale_r <= adc_deadzone_r) ||
                  (in_throttle_raw >= adc_full_scale_r);
      brake_r  <= !in_brake_pin;
      regen_r  <= !in_regen_pin;
      sel_a_r  <= in_selector_pin_a;
      sel_b_r  <= in_selector_pin_b;
      charge_r <= in_charge_below_limit;
      temp_r   <= in_temperature_ok;
      slow_r   <= in_speed_below_limit;
      cruise_r <= in_cruise_request;
    end
    pedal_r <= pedal_nxt;
  end

  // Pick the pedal value once the quotient is in
  always_comb begin
    pedal_nxt = pedal_r;
    if ((st_r == ST_DIV) && div_rsp.done) begin
      if (zero_r) begin
        pedal_nxt = '0;
      end else if (full_r) begin
        pedal_nxt = FULL_THROTTLE;
      end else begin
        pedal_nxt = CMD_W'(div_rsp.quot);
      end
    end
  end

  // Advance the sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (accept) st_nxt = ST_DIV;
      ST_DIV:  if (div_rsp.done) st_nxt = ST_DONE;
      ST_DONE: if (load_out) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Form the command and the next mode
  assign sel_drive  = !sel_a_r && !sel_b_r;
  assign sel_rev    = sel_a_r && sel_b_r;
  assign sel_park   = !sel_drive && !sel_rev;
  assign mn_thr     = (min_throttle_r > FULL_THROTTLE) ? FULL_THROTTLE : min_throttle_r;
  assign cr_thr     = (cruise_throttle_r > FULL_THROTTLE) ? FULL_THROTTLE : cruise_throttle_r;
  assign regen_case = regen_r && charge_r && temp_r;

  always_comb begin
    thr      = '0;
    vel      = '0;
    mode_nxt = mode_r;
    case (mode_r)
      MODE_DRIVE, MODE_REVERSE: begin
        if (brake_r) begin
          thr = '0;
          vel = '0;
        end else if ((mode_r == MODE_DRIVE) && regen_case) begin
          thr = pedal_r;
          vel = (pedal_r == '0) ? '0 : VEL_FWD;
        end else if (!motor_type_r && (pedal_r == '0)) begin
          thr = '0;
          vel = '0;
        end else if (!motor_type_r && (pedal_r < mn_thr)) begin
          thr = mn_thr;
          vel = '0;
        end else begin
          thr = pedal_r;
          vel = (mode_r == MODE_DRIVE) ? VEL_FWD : VEL_REV;
        end
        if (mode_r == MODE_DRIVE) begin
          if (sel_rev && slow_r) mode_nxt = MODE_REVERSE;
          else if (sel_park && slow_r) mode_nxt = MODE_PARK;
          else if (cruise_r) mode_nxt = MODE_CRUISE;
        end else begin
          if (sel_drive && brake_r && slow_r) mode_nxt = MODE_DRIVE;
          else if (sel_park && brake_r && slow_r) mode_nxt = MODE_PARK;
        end
      end
      MODE_PARK: begin
        thr = FULL_THROTTLE;
        vel = '0;
        if (sel_drive && brake_r && slow_r) mode_nxt = MODE_DRIVE;
        else if (sel_rev && brake_r && slow_r) mode_nxt = MODE_REVERSE;
      end
      default: begin
        thr = cr_thr;
        vel = cruise_velocity_r;
        if (brake_r || !cruise_r) mode_nxt = MODE_DRIVE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      mode_r      <= MODE_PARK;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out) begin
        mode_r      <= mode_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_thr_r  <= thr;
      out_vel_r  <= vel;
      out_used_r <= mode_r;
      out_next_r <= mode_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_throttle_cmd = out_thr_r;
  assign out_velocity_cmd = out_vel_r;
  assign out_mode_used    = out_used_r;
  assign out_mode_next    = out_next_r;

  `VDMC_ASSERT_NEXT(a_accept_starts_div, accept, st_r == ST_DIV, "tick did not start division")
  `VDMC_ASSERT_NOW(a_done_in_div, div_rsp.done, st_r == ST_DIV, "divider done outside division")
  `VDMC_ASSERT_NOW(a_thr_in_range, out_valid_r, out_thr_r <= FULL_THROTTLE, "throttle above full")
  `VDMC_ASSERT_NEXT(a_mode_holds, !load_out, mode_r == $past(mode_r), "mode changed without result")

endmodule

@@ sv/vdmc_div.sv @@
// Serial restoring divider for the throttle map: one quotient bit per cycle.
// Depends on vdmc_pkg. Dividend must be below the divisor for a valid result.
`timescale 1ns / 1ps

module vdmc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  vdmc_pkg::div_req_t req,
  output vdmc_pkg::div_rsp_t rsp
);
  import vdmc_pkg::*;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [ADC_BITS-1:0]           rem_r, rem_nxt;
  logic [ADC_BITS-1:0]           dvs_r, dvs_nxt;
  logic [THROTTLE_FRAC_BITS-1:0] quot_r, quot_nxt;
  logic [ADC_BITS:0]             shifted;
  logic [ADC_BITS+1:0]           trial;
  logic                          fits;

  // Shared shift-and-subtract step
  assign shifted = {rem_r, 1'b0};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};
  assign fits    = ~trial[ADC_BITS+1];

  // Sequence the steps
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quot_nxt = quot_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(THROTTLE_FRAC_BITS);
      rem_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quot_nxt = {quot_r[THROTTLE_FRAC_BITS-2:0], fits};
      rem_nxt  = fits ? trial[ADC_BITS-1:0] : shifted[ADC_BITS-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

@@ tb/sv/vdmc_command_checker.sv @@
// Checker for the drive-mode controller: follows register writes and input transfers,
// predicts each command and compares it with the result channel. Depends on vdmc_pkg.
`timescale 1ns / 1ps

module vdmc_command_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [vdmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vdmc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [vdmc_pkg::ADC_BITS-1:0]      in_throttle_raw,
  input  logic                               in_brake_pin,
  input  logic                               in_regen_pin,
  input  logic                               in_selector_pin_a,
  input  logic                               in_selector_pin_b,
  input  logic                               in_charge_below_limit,
  input  logic                               in_temperature_ok,
  input  logic                               in_speed_below_limit,
  input  logic                               in_cruise_request,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [vdmc_pkg::CMD_W-1:0]         out_throttle_cmd,
  input  logic signed [vdmc_pkg::CMD_W-1:0]  out_velocity_cmd,
  input  logic [1:0]                         out_mode_used,
  input  logic [1:0]                         out_mode_next,
  output int                                 predicted_cnt,
  output int                                 checked_cnt,
  output int                                 error_cnt
);
  import vdmc_pkg::*;

  typedef struct packed {
    logic [ADC_BITS-1:0] throttle_raw;
    logic                brake_pin;
    logic                regen_pin;
    logic                selector_pin_a;
    logic                selector_pin_b;
    logic                charge_below_limit;
    logic                temperature_ok;
    logic                speed_below_limit;
    logic                cruise_request;
  } tick_t;

  typedef struct packed {
    logic [CMD_W-1:0]        throttle;
    logic signed [CMD_W-1:0] velocity;
    logic [1:0]              mode_used;
    logic [1:0]              mode_next;
  } cmd_t;

  // Shadow copy of the register file and the mode
  logic                    cfg_motor_type;
  logic [ADC_BITS-1:0]     cfg_deadzone;
  logic [ADC_BITS-1:0]     cfg_full_scale;
  logic [CMD_W-1:0]        cfg_min_throttle;
  logic [CMD_W-1:0]        cfg_cruise_throttle;
  logic signed [CMD_W-1:0] cfg_cruise_velocity;
  logic [1:0]              drive_mode;

  // Commands still owed by the block, oldest first
  cmd_t pending_cmds[$];

  function automatic logic [CMD_W-1:0] sat_full(input logic [31:0] v);
    return (v > FULL_THROTTLE) ? FULL_THROTTLE : v[CMD_W-1:0];
  endfunction

  // Map the raw sample past the deadzone to unsigned UQ1.15 pedal travel
  function automatic logic [CMD_W-1:0] pedal_from_raw(input logic [ADC_BITS-1:0] raw);
    logic [31:0] span;
    logic [31:0] scaled;
    if (raw <= cfg_deadzone) return '0;
    if (cfg_full_scale <= cfg_deadzone) return FULL_THROTTLE;
    span   = 32'(cfg_full_scale - cfg_deadzone);
    scaled = 32'(raw - cfg_deadzone) << THROTTLE_FRAC_BITS;
    return sat_full(scaled / span);
  endfunction

  // Controller-type rules shared by drive and reverse
  function automatic cmd_t motor_cmd(input logic [CMD_W-1:0] pedal,
                                     input logic signed [CMD_W-1:0] move_vel);
    cmd_t             c;
    logic [CMD_W-1:0] floor_thr;
    c = '0;
    floor_thr = sat_full(32'(cfg_min_throttle));
    if (cfg_motor_type) begin
      c.throttle = pedal;
      c.velocity = move_vel;
    end else if (pedal != '0) begin
      if (pedal < floor_thr) begin
        c.throttle = floor_thr;
      end else begin
        c.throttle = pedal;
        c.velocity = move_vel;
      end
    end
    return c;
  endfunction

  function automatic cmd_t predict_cmd(input tick_t t);
    cmd_t             c;
    logic [CMD_W-1:0] pedal;
    logic [1:0]       next_mode;
    logic             brake_on;
    logic             regen_on;
    logic             sel_drive;
    logic             sel_rev;
    logic             sel_park;
    logic             slow;
    pedal     = pedal_from_raw(t.throttle_raw);
    brake_on  = !t.brake_pin;
    regen_on  = !t.regen_pin;
    sel_drive = !t.selector_pin_a && !t.selector_pin_b;
    sel_rev   = t.selector_pin_a && t.selector_pin_b;
    sel_park  = !sel_drive && !sel_rev;
    slow      = t.speed_below_limit;
    next_mode = drive_mode;
    c = '0;
    case (drive_mode)
      MODE_DRIVE: begin
        if (!brake_on) begin
          if (regen_on && t.charge_below_limit && t.temperature_ok) begin
            c.throttle = pedal;
            c.velocity = (pedal == '0) ? '0 : VEL_FWD;
          end else begin
            c = motor_cmd(pedal, VEL_FWD);
          end
        end
        if (sel_rev && slow) next_mode = MODE_REVERSE;
        else if (sel_park && slow) next_mode = MODE_PARK;
        else if (t.cruise_request) next_mode = MODE_CRUISE;
      end
      MODE_REVERSE: begin
        if (!brake_on) c = motor_cmd(pedal, VEL_REV);
        if (sel_drive && brake_on && slow) next_mode = MODE_DRIVE;
        else if (sel_park && brake_on && slow) next_mode = MODE_PARK;
      end
      MODE_PARK: begin
        c.throttle = FULL_THROTTLE;
        if (sel_drive && brake_on && slow) next_mode = MODE_DRIVE;
        else if (sel_rev && brake_on && slow) next_mode = MODE_REVERSE;
      end
      default: begin
        c.throttle = sat_full(32'(cfg_cruise_throttle));
        c.velocity = cfg_cruise_velocity;
        if (brake_on || !t.cruise_request) next_mode = MODE_DRIVE;
      end
    endcase
    c.mode_used = drive_mode;
    c.mode_next = next_mode;
    return c;
  endfunction

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch
    tick_t tick;
    cmd_t  want;
    if (!rst_n) begin
      cfg_motor_type      = 1'b1;
      cfg_deadzone        = 12'd100;
      cfg_full_scale      = 12'd4095;
      cfg_min_throttle    = '0;
      cfg_cruise_throttle = FULL_THROTTLE;
      cfg_cruise_velocity = '0;
      drive_mode          = MODE_PARK;
      pending_cmds.delete();
      predicted_cnt       = 0;
      checked_cnt         = 0;
      error_cnt           = 0;
    end else begin
      // Check the result first: it always belongs to an earlier tick
      if (out_valid && !out_stall) begin
        if (pending_cmds.size() == 0) begin
          $error("command transfer with nothing outstanding: throttle %0d velocity %0d",
                 out_throttle_cmd, out_velocity_cmd);
          error_cnt++;
        end else begin
          want = pending_cmds.pop_front();
          compare_field("throttle_cmd", 32'(want.throttle), 32'(out_throttle_cmd));
          compare_field("velocity_cmd", 32'($signed(want.velocity)),
                        32'($signed(out_velocity_cmd)));
          compare_field("mode_used", 32'(want.mode_used), 32'(out_mode_used));
          compare_field("mode_next", 32'(want.mode_next), 32'(out_mode_next));
          checked_cnt++;
        end
      end
      // Predict on each input transfer and advance the mode
      if (in_valid && !in_stall) begin
        tick.throttle_raw       = in_throttle_raw;
        tick.brake_pin          = in_brake_pin;
        tick.regen_pin          = in_regen_pin;
        tick.selector_pin_a     = in_selector_pin_a;
        tick.selector_pin_b     = in_selector_pin_b;
        tick.charge_below_limit = in_charge_below_limit;
        tick.temperature_ok     = in_temperature_ok;
        tick.speed_below_limit  = in_speed_below_limit;
        tick.cruise_request     = in_cruise_request;
        want = predict_cmd(tick);
        drive_mode = want.mode_next;
        pending_cmds.push_back(want);
        predicted_cnt++;
      end
      // Follow register writes; unused indexes drop
      if (cfg_we) begin
        case (cfg_index)
          CFG_MOTOR_TYPE:      cfg_motor_type      = cfg_data[0];
          CFG_ADC_DEADZONE:    cfg_deadzone        = cfg_data[ADC_BITS-1:0];
          CFG_ADC_FULL_SCALE:  cfg_full_scale      = cfg_data[ADC_BITS-1:0];
          CFG_MIN_THROTTLE:    cfg_min_throttle    = cfg_data;
          CFG_CRUISE_THROTTLE: cfg_cruise_throttle = cfg_data;
          CFG_CRUISE_VELOCITY: cfg_cruise_velocity = cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/sv/vehicle_drive_mode_controller_core_tb.sv @@
// Testbench top for the drive-mode controller: clock, reset, register setup,
// tick stimulus and result stalls. Depends on vdmc_pkg, the block and vdmc_command_checker.
`timescale 1ns / 1ps

module vehicle_drive_mode_controller_core_tb;
  import vdmc_pkg::*;

  localparam int RAW_MAX         = (1 << ADC_BITS) - 1;
  localparam int IDLE_LIMIT      = 4000;
  localparam int LONG_HOLD       = 300;
  localparam int RANDOM_PHASES   = 8;
  localparam int TICKS_PER_PHASE = 160;
  localparam int HOLD_BURST      = 40;
  localparam int SETTLE_CYCLES   = 40;

  // Indexes past the register file; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_style_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] throttle_raw;
    logic                brake_pin;
    logic                regen_pin;
    logic                selector_pin_a;
    logic                selector_pin_b;
    logic                charge_below_limit;
    logic                temperature_ok;
    logic                speed_below_limit;
    logic                cruise_request;
  } tick_t;

  logic                    clk;
  logic                    rst_n                 = 1'b0;
  logic                    cfg_we                = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index             = '0;
  logic [CFG_W-1:0]        cfg_data              = '0;
  logic                    in_valid              = 1'b0;
  logic                    in_stall;
  logic [ADC_BITS-1:0]     in_throttle_raw       = '0;
  logic                    in_brake_pin          = 1'b1;
  logic                    in_regen_pin          = 1'b1;
  logic                    in_selector_pin_a     = 1'b0;
  logic                    in_selector_pin_b     = 1'b0;
  logic                    in_charge_below_limit = 1'b0;
  logic                    in_temperature_ok     = 1'b0;
  logic                    in_speed_below_limit  = 1'b0;
  logic                    in_cruise_request     = 1'b0;
  logic                    out_valid;
  logic                    out_stall             = 1'b0;
  logic [CMD_W-1:0]        out_throttle_cmd;
  logic signed [CMD_W-1:0] out_velocity_cmd;
  logic [1:0]              out_mode_used;
  logic [1:0]              out_mode_next;
  int                      predicted_cnt;
  int                      checked_cnt;
  int                      error_cnt;

  // Stimulus bookkeeping
  int                  hold_reqs      = 0;
  int                  settings_used  = 0;
  logic [ADC_BITS-1:0] cur_deadzone   = 12'd100;
  logic [ADC_BITS-1:0] cur_full_scale = 12'd4095;
  int                  seq_left       = 0;
  logic [1:0]          seq_selector   = '0;
  logic                seq_cruise     = 1'b0;

  vehicle_drive_mode_controller_core uut (.*);
  vdmc_command_checker command_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tick_t tick_of(input int raw, input logic brake, input logic regen,
                                    input logic sel_a, input logic sel_b, input logic charge,
                                    input logic temp_ok, input logic slow, input logic cruise);
    tick_t t;
    t.throttle_raw       = raw[ADC_BITS-1:0];
    t.brake_pin          = brake;
    t.regen_pin          = regen;
    t.selector_pin_a     = sel_a;
    t.selector_pin_b     = sel_b;
    t.charge_below_limit = charge;
    t.temperature_ok     = temp_ok;
    t.speed_below_limit  = slow;
    t.cruise_request     = cruise;
    return t;
  endfunction

  // Favor samples near the deadzone and full-scale edges and at both ends of the ADC range
  function automatic logic [ADC_BITS-1:0] pick_raw();
    int v;
    case ($urandom_range(0, 5))
      0:       v = int'(cur_deadzone) + int'($urandom_range(0, 2)) - 1;
      1:       v = int'(cur_full_scale) + int'($urandom_range(0, 2)) - 1;
      2:       v = 0;
      3:       v = RAW_MAX;
      default: v = $urandom_range(0, RAW_MAX);
    endcase
    if (v < 0) v = 0;
    if (v > RAW_MAX) v = RAW_MAX;
    return v[ADC_BITS-1:0];
  endfunction

  // Mostly driving sequences (selector held, shift opened by brake and low speed),
  // the rest pure noise
  function automatic tick_t next_tick();
    tick_t       t;
    logic [31:0] noise;
    if ($urandom_range(0, 4) == 0) begin
      noise = $urandom;
      t = noise[$bits(tick_t)-1:0];
      return t;
    end
    if (seq_left == 0) begin
      seq_left     = $urandom_range(3, 24);
      seq_selector = 2'($urandom_range(0, 3));
      seq_cruise   = ($urandom_range(0, 2) != 0);
      t.brake_pin         = 1'b0;
      t.speed_below_limit = 1'b1;
    end else begin
      t.brake_pin         = ($urandom_range(0, 9) != 0);
      t.speed_below_limit = 1'($urandom_range(0, 1));
    end
    seq_left--;
    t.throttle_raw       = pick_raw();
    t.regen_pin          = 1'($urandom_range(0, 1));
    t.charge_below_limit = 1'($urandom_range(0, 1));
    t.temperature_ok     = 1'($urandom_range(0, 1));
    {t.selector_pin_a, t.selector_pin_b} = seq_selector;
    t.cruise_request     = ($urandom_range(0, 9) == 0) ? !seq_cruise : seq_cruise;
    return t;
  endfunction

  // Offer one tick and hold it until the transfer
  task automatic send_tick(input tick_t t);
    @(negedge clk);
    in_valid              <= 1'b1;
    in_throttle_raw       <= t.throttle_raw;
    in_brake_pin          <= t.brake_pin;
    in_regen_pin          <= t.regen_pin;
    in_selector_pin_a     <= t.selector_pin_a;
    in_selector_pin_b     <= t.selector_pin_b;
    in_charge_below_limit <= t.charge_below_limit;
    in_temperature_ok     <= t.temperature_ok;
    in_speed_below_limit  <= t.speed_below_limit;
    in_cruise_request     <= t.cruise_request;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic idle_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic drain_results();
    idle_gap(1);
    do @(negedge clk); while (predicted_cnt != checked_cnt);
  endtask

  task automatic run_traffic(input int n_ticks);
    int left;
    int burst;
    left = n_ticks;
    while (left > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      while (burst > 0 && left > 0) begin
        send_tick(next_tick());
        burst--;
        left--;
      end
      idle_gap($urandom_range(1, 24));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ADC_DEADZONE) cur_deadzone = value[ADC_BITS-1:0];
    if (idx == CFG_ADC_FULL_SCALE) cur_full_scale = value[ADC_BITS-1:0];
  endtask

  task automatic set_all(input logic [CFG_W-1:0] mt, input logic [CFG_W-1:0] dz,
                         input logic [CFG_W-1:0] fs, input logic [CFG_W-1:0] mn,
                         input logic [CFG_W-1:0] ct, input logic [CFG_W-1:0] cv);
    write_reg(CFG_MOTOR_TYPE, mt);
    write_reg(CFG_ADC_DEADZONE, dz);
    write_reg(CFG_ADC_FULL_SCALE, fs);
    write_reg(CFG_MIN_THROTTLE, mn);
    write_reg(CFG_CRUISE_THROTTLE, ct);
    write_reg(CFG_CRUISE_VELOCITY, cv);
    settings_used++;
  endtask

  // Extremes first, then deadzone over full scale, then random settings
  task automatic apply_settings(input int phase);
    logic [CFG_W-1:0] mt;
    logic [CFG_W-1:0] dz;
    logic [CFG_W-1:0] fs;
    logic [CFG_W-1:0] mn;
    logic [CFG_W-1:0] ct;
    logic [CFG_W-1:0] cv;
    logic [31:0]      junk;
    mn = CFG_W'(($urandom_range(0, 5) == 0) ? $urandom_range(32769, 65535)
                                            : $urandom_range(0, 32768));
    ct = CFG_W'(($urandom_range(0, 5) == 0) ? $urandom_range(32769, 65535)
                                            : $urandom_range(0, 32768));
    cv = CFG_W'($urandom);
    case (phase)
      0: begin
        mt = 0; dz = 0; fs = 1; mn = 0; ct = 0; cv = 16'h8000;
      end
      1: begin
        mt = 1; dz = 4094; fs = 4095; mn = 16'h8000; ct = 16'h8000; cv = 16'h7FFF;
      end
      2: begin
        mt = CFG_W'($urandom_range(0, 1));
        fs = CFG_W'($urandom_range(1, 2000));
        dz = CFG_W'($urandom_range(fs, 4094));
      end
      default: begin
        mt = CFG_W'($urandom_range(0, 1));
        dz = CFG_W'($urandom_range(0, 800));
        fs = CFG_W'($urandom_range(dz + 1, RAW_MAX));
        // Upper data bits beyond a register's width must be ignored
        if ($urandom_range(0, 1) == 1) begin
          junk = $urandom;
          mt[CFG_W-1:1]        = junk[14:0];
          dz[CFG_W-1:ADC_BITS] = junk[18:15];
          fs[CFG_W-1:ADC_BITS] = junk[22:19];
        end
      end
    endcase
    set_all(mt, dz, fs, mn, ct, cv);
    write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_W'($urandom));
  endtask

  // Result side: stall patterns of its own, plus the long hold-off on request
  initial begin : result_sink
    sink_style_t style;
    int          style_left;
    int          served;
    style      = SINK_OPEN;
    style_left = 0;
    served     = 0;
    forever begin
      @(negedge clk);
      if (served != hold_reqs) begin
        served = hold_reqs;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        if (style_left == 0) begin
          style      = sink_style_t'($urandom_range(0, 3));
          style_left = $urandom_range(20, 200);
        end
        style_left--;
        case (style)
          SINK_OPEN:  out_stall <= 1'b0;
          SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          SINK_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:    out_stall <= ((style_left % 7) < 3);
        endcase
      end
    end
  end

  // Stop the run when no transfer happens for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Minimum-throttle rules with pedal = 16 * raw, floor exactly at raw 100,
    // cruise throttle above full
    set_all(0, 0, 2048, 1600, 16'hFFFF, 16'h8000);
    send_tick(tick_of(4095, 1, 1, 0, 0, 1, 1, 1, 1));  // park, brake released: hold park
    send_tick(tick_of(0,    0, 1, 1, 1, 0, 0, 1, 0));  // park to reverse
    send_tick(tick_of(0,    1, 1, 1, 1, 0, 0, 0, 0));  // reverse, zero pedal
    send_tick(tick_of(99,   1, 0, 1, 1, 1, 1, 0, 1));  // below floor, regen ignored
    send_tick(tick_of(100,  1, 1, 1, 1, 0, 0, 1, 0));  // pedal equal to floor
    send_tick(tick_of(4095, 1, 1, 0, 0, 0, 0, 1, 0));  // saturated pedal, no brake: hold
    send_tick(tick_of(2048, 0, 1, 0, 0, 0, 0, 0, 0));  // brake but too fast: hold reverse
    send_tick(tick_of(2048, 0, 1, 0, 0, 0, 0, 1, 0));  // reverse to drive
    send_tick(tick_of(0,    1, 0, 0, 0, 1, 1, 0, 0));  // regen, zero pedal
    send_tick(tick_of(50,   1, 0, 0, 0, 1, 1, 0, 0));  // regen, below floor passes
    send_tick(tick_of(99,   1, 0, 0, 0, 1, 0, 0, 0));  // regen blocked by temperature
    send_tick(tick_of(100,  1, 1, 0, 0, 0, 1, 0, 0));  // drive at the floor
    send_tick(tick_of(4095, 0, 1, 0, 0, 0, 0, 0, 1));  // brake, drive to cruise
    send_tick(tick_of(0,    1, 1, 1, 1, 0, 0, 1, 1));  // cruise holds
    send_tick(tick_of(0,    1, 1, 0, 0, 0, 0, 0, 0));  // request cleared, back to drive
    send_tick(tick_of(300,  1, 1, 1, 0, 0, 0, 0, 1));  // park selected but fast: cruise
    send_tick(tick_of(0,    0, 1, 0, 1, 0, 0, 0, 1));  // brake leaves cruise
    send_tick(tick_of(0,    1, 1, 0, 1, 0, 0, 1, 1));  // park wins over cruise
    send_tick(tick_of(0,    0, 1, 1, 0, 1, 1, 1, 1));  // park selected in park
    send_tick(tick_of(0,    0, 1, 0, 0, 0, 0, 1, 0));  // park to drive
    send_tick(tick_of(0,    1, 1, 1, 1, 0, 0, 1, 1));  // drive to reverse without brake
    send_tick(tick_of(0,    0, 1, 0, 1, 0, 0, 1, 0));  // reverse to park
    drain_results();

    // Other controller rules with full scale below the deadzone
    set_all(1, 4094, 1, 0, 16'h8000, 0);
    send_tick(tick_of(0,    0, 1, 0, 0, 0, 0, 1, 0));  // park to drive
    send_tick(tick_of(4095, 1, 1, 0, 0, 0, 0, 0, 0));  // above deadzone: full
    send_tick(tick_of(4094, 1, 1, 0, 0, 0, 0, 0, 0));  // zero pedal still moves
    drain_results();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_settings(p);
      if (p == 3) begin
        // Keep offering while the result side holds off, so the input backs up
        hold_reqs++;
        repeat (HOLD_BURST) send_tick(next_tick());
        idle_gap(1);
        run_traffic(TICKS_PER_PHASE - HOLD_BURST);
      end else if (p == 5) begin
        run_traffic(TICKS_PER_PHASE / 2);
        drain_results();
        run_traffic(TICKS_PER_PHASE / 2);
      end else begin
        run_traffic(TICKS_PER_PHASE);
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d control ticks over %0d register settings, with sender gaps,",
             checked_cnt, settings_used);
    $display("result stalls, a long result hold-off and full drains between settings.");
    if (error_cnt == 0 && predicted_cnt == checked_cnt) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/vdmc_pkg.sv
sv/vdmc_div.sv
sv/vehicle_drive_mode_controller_core.sv
tb/sv/vdmc_command_checker.sv
tb/sv/vehicle_drive_mode_controller_core_tb.sv
